/* rtl/core/hmpq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hmpq_pkg
// shared types and constants for the min-heap priority queue cell chain
// ----------------------------------------------------------------------------
package hmpq_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int LIMIT_W     = 5;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_PEEK    = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd         cmd;
        logic signed [KEY_W-1:0] key;
    } t_cell_ctl;

endpackage : hmpq_pkg
`default_nettype wire

/* rtl/core/hmpq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hmpq_cell
// one slot of the sorted key chain, smallest key at the head
// ----------------------------------------------------------------------------
module hmpq_cell (
    input  wire logic                          i_clk,
    input  wire hmpq_pkg::t_cell_ctl           i_ctl,
    input  wire logic                          i_occ,
    input  wire logic                          i_left_move,
    input  wire logic signed [hmpq_pkg::KEY_W-1:0] i_left_key,
    input  wire logic signed [hmpq_pkg::KEY_W-1:0] i_right_key,
    output logic signed [hmpq_pkg::KEY_W-1:0]  o_key,
    output logic                               o_move
);
    import hmpq_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;

    // this slot and all to its right make room for the new key
    assign o_move = !i_occ || (i_ctl.key < r_key);

    always_comb begin
        n_key = r_key;
        case (i_ctl.cmd)
            CELL_INSERT: begin
                if (o_move) begin
                    n_key = i_left_move ? i_left_key : i_ctl.key;
                end
            end
            CELL_SHIFT: n_key = i_right_key;
            default:    n_key = r_key;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule : hmpq_cell
`default_nettype wire

/* rtl/core/min_heap_priority_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// min-priority queue of signed keys held sorted in a chain of cells
// ----------------------------------------------------------------------------
// o_done is registered: an accepted start sets r_pend, and r_done follows r_pend
// a new word is not accepted while one is pending in the command register
//   ahead of the cell chain; busy is high while a command is pending
// every result is strobed for one cycle; the receiver cannot stall
// reset: count clears to zero and the limit to 16; keys are not cleared,
//   only slots below the count are ever read
// ----------------------------------------------------------------------------
module min_heap_priority_queue (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [hmpq_pkg::LIMIT_W-1:0]          i_cfg_data,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [hmpq_pkg::OP_W-1:0]             i_op,
    input  wire logic signed [hmpq_pkg::KEY_W-1:0]     i_key_in,
    output logic                                       o_done,
    output logic signed [hmpq_pkg::KEY_W-1:0]          o_key_out,
    output logic [hmpq_pkg::STATUS_W-1:0]              o_status,
    output logic [hmpq_pkg::COUNT_W-1:0]               o_count
);
    import hmpq_pkg::*;

    // control state
    logic                 r_pend;
    logic                 r_done;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [LIMIT_W-1:0]   r_limit;

    // accepted command word
    logic [OP_W-1:0]          r_op;
    logic signed [KEY_W-1:0]  r_key;

    // result registers
    logic signed [KEY_W-1:0]  r_key_out;
    logic signed [KEY_W-1:0]  n_key_out;
    t_status                  r_status;
    t_status                  n_status;
    logic [COUNT_W-1:0]       r_count_out;

    t_cell_ctl                w_ctl;
    t_cell_cmd                w_cmd;
    logic                     w_full;

    // cell chain taps
    logic signed [KEY_W-1:0]  w_key  [MAX_ENTRIES];
    logic                     w_move [MAX_ENTRIES];
    logic                     w_occ  [MAX_ENTRIES];

    wire logic w_accept = start && !r_pend;

    // full when count reaches the limit or the chain length
    assign w_full = (CMP_W'(r_count) >= CMP_W'(r_limit))
                 || (r_count >= CNT_W'(MAX_ENTRIES));

    // decode the pending command into a chain action and a result
    always_comb begin
        w_cmd     = CELL_HOLD;
        n_count   = r_count;
        n_status  = ST_OK;
        n_key_out = '0;
        if (r_pend) begin
            case (r_op)
                OP_INSERT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_cmd   = CELL_INSERT;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_EXTRACT: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_cmd     = CELL_SHIFT;
                        n_key_out = w_key[0];
                        n_count   = r_count - CNT_W'(1);
                    end
                end
                OP_PEEK: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_key_out = w_key[0];
                    end
                end
                default: begin
                    // unused code: no change, ok status
                    n_status = ST_OK;
                end
            endcase
        end
    end

    assign w_ctl = '{cmd: w_cmd, key: r_key};

    // chain of cells, head holds the smallest key
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        assign w_occ[g] = (CNT_W'(g) < r_count);
        if (g == 0) begin : g_head
            if (MAX_ENTRIES > 1) begin : g_more
                hmpq_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (w_ctl),
                    .i_occ       (w_occ[g]),
                    .i_left_move (1'b0),
                    .i_left_key  (r_key),
                    .i_right_key (w_key[g+1]),
                    .o_key       (w_key[g]),
                    .o_move      (w_move[g])
                );
            end else begin : g_one
                hmpq_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (w_ctl),
                    .i_occ       (w_occ[g]),
                    .i_left_move (1'b0),
                    .i_left_key  (r_key),
                    .i_right_key (w_key[g]),
                    .o_key       (w_key[g]),
                    .o_move      (w_move[g])
                );
            end
        end else if (g == MAX_ENTRIES - 1) begin : g_tail
            // tail has no right neighbor; a shift leaves it stale
            hmpq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (w_occ[g]),
                .i_left_move (w_move[g-1]),
                .i_left_key  (w_key[g-1]),
                .i_right_key (w_key[g]),
                .o_key       (w_key[g]),
                .o_move      (w_move[g])
            );
        end else begin : g_mid
            hmpq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (w_occ[g]),
                .i_left_move (w_move[g-1]),
                .i_left_key  (w_key[g-1]),
                .i_right_key (w_key[g+1]),
                .o_key       (w_key[g]),
                .o_move      (w_move[g])
            );
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
            r_limit <= LIMIT_RESET;
        end else begin
            r_pend  <= w_accept;
            r_done  <= r_pend;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // command capture and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_op;
            r_key <= i_key_in;
        end
        if (r_pend) begin
            r_key_out   <= n_key_out;
            r_status    <= n_status;
            r_count_out <= COUNT_W'(n_count);
        end
    end

    assign busy      = r_pend;
    assign o_done    = r_done;
    assign o_key_out = r_key_out;
    assign o_status  = r_status;
    assign o_count   = r_count_out;

    // count never runs past the chain length
    a_count_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("count beyond chain length");

    // a result follows only a pending command
    a_done_after_pend : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_pend))
        else $error("result without a command");

    // refused or empty operations leave the count alone
    a_err_keeps_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> (r_count == $past(r_count)))
        else $error("count changed on error");

    // head of the chain holds a key no larger than the next slot
    if (MAX_ENTRIES > 1) begin : g_sort_chk
        a_head_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_count >= CNT_W'(2)) |-> !(w_key[1] < w_key[0]))
            else $error("chain head out of order");
    end

endmodule : min_heap_priority_queue
`default_nettype wire
